@@ hdl/b2da_pkg.sv @@
`timescale 1ns / 1ps

package b2da_pkg;

  localparam int VALUE_BITS_DEF = 32;
  localparam int IN_W           = 32;
  localparam int CHAR_W         = 6;
  localparam int DIGIT_W        = 4;
  localparam int BITS_PER_STEP  = 4;

  localparam logic [CHAR_W-1:0]  ASCII_ZERO = CHAR_W'(48);
  localparam logic [DIGIT_W-1:0] DD_THRESH  = DIGIT_W'(5);
  localparam logic [DIGIT_W-1:0] DD_ADJUST  = DIGIT_W'(3);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_EMIT
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic load;
    logic conv;
    logic shift;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic top_zero;
  } stat_t;

endpackage

@@ hdl/b2da_dp.sv @@
`timescale 1ns / 1ps

module b2da_dp import b2da_pkg::*; #(
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic              clk,
  input  logic [IN_W-1:0]   in_value,
  input  cmd_t              cmd,
  output stat_t             stat,
  output logic [CHAR_W-1:0] digit_char
);

  localparam int EFF   = (VALUE_BITS > IN_W) ? IN_W : VALUE_BITS;
  localparam int STEPS = (EFF + BITS_PER_STEP - 1) / BITS_PER_STEP;
  localparam int PAD   = STEPS * BITS_PER_STEP;
  localparam int ND    = (EFF * 1233) / 4096 + 1;
  localparam int BW    = ND * DIGIT_W;

  logic [PAD-1:0] val_r, val_nxt, val_s;
  logic [BW-1:0]  bcd_r, bcd_nxt, bcd_s;
  logic [DIGIT_W-1:0] top_digit;

  // double dabble, BITS_PER_STEP input bits per cycle while cmd.conv is high
  always_comb begin
    bcd_s = bcd_r;
    val_s = val_r;
    for (int s = 0; s < BITS_PER_STEP; s++) begin
      for (int d = 0; d < ND; d++) begin
        if (bcd_s[d*DIGIT_W +: DIGIT_W] >= DD_THRESH) begin
          bcd_s[d*DIGIT_W +: DIGIT_W] = bcd_s[d*DIGIT_W +: DIGIT_W] + DD_ADJUST;
        end
      end
      {bcd_s, val_s} = {bcd_s[BW-2:0], val_s, 1'b0};
    end
  end

  always_comb begin
    val_nxt = val_r;
    bcd_nxt = bcd_r;
    priority if (cmd.load) begin
      val_nxt = PAD'(in_value[EFF-1:0]);
      bcd_nxt = '0;
    end else if (cmd.conv) begin
      val_nxt = val_s;
      bcd_nxt = bcd_s;
    end else if (cmd.shift) begin
      bcd_nxt = {bcd_r[BW-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
    bcd_r <= bcd_nxt;
  end

  assign top_digit     = bcd_r[BW-1 -: DIGIT_W];
  assign stat.top_zero = (top_digit == '0);
  assign digit_char    = ASCII_ZERO + CHAR_W'(top_digit);

endmodule

@@ hdl/b2da_ctrl.sv @@
`timescale 1ns / 1ps

module b2da_ctrl import b2da_pkg::*; #(
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  start,
  input  stat_t stat,
  output cmd_t  cmd,
  output logic  busy,
  output logic  out_valid,
  output logic  out_last
);

  localparam int EFF     = (VALUE_BITS > IN_W) ? IN_W : VALUE_BITS;
  localparam int STEPS   = (EFF + BITS_PER_STEP - 1) / BITS_PER_STEP;
  localparam int ND      = (EFF * 1233) / 4096 + 1;
  localparam int CNT_MAX = (STEPS > ND) ? STEPS : ND;
  localparam int CW      = $clog2(CNT_MAX + 1);

  state_t state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic started_r, started_nxt;
  logic cnt_one;

  assign cnt_one = (cnt_r == CW'(1));

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (start) state_nxt = ST_CONV;
      ST_CONV: if (cnt_one) state_nxt = ST_EMIT;
      ST_EMIT: if (cnt_one) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd         = '0;
    busy        = 1'b1;
    out_valid   = 1'b0;
    out_last    = 1'b0;
    cnt_nxt     = cnt_r;
    started_nxt = started_r;
    unique case (state_r)
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.load = 1'b1;
          cnt_nxt  = CW'(STEPS);
        end
      end
      ST_CONV: begin
        cmd.conv = 1'b1;
        if (cnt_one) begin
          cnt_nxt     = CW'(ND);
          started_nxt = 1'b0;
        end else begin
          cnt_nxt = cnt_r - CW'(1);
        end
      end
      ST_EMIT: begin
        // leading zeros are skipped; the final digit always goes out
        cmd.shift   = 1'b1;
        out_valid   = started_r | ~stat.top_zero | cnt_one;
        out_last    = cnt_one;
        started_nxt = started_r | out_valid;
        cnt_nxt     = cnt_r - CW'(1);
      end
      default: busy = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      cnt_r     <= '0;
      started_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      cnt_r     <= cnt_nxt;
      started_r <= started_nxt;
    end
  end

endmodule

@@ hdl/binary_to_decimal_ascii_core.sv @@
`timescale 1ns / 1ps
// Binary to decimal ASCII converter.
// Input: pulse start with in_value while busy is low; that edge accepts the
// transaction and busy rises on the next cycle. Only the low VALUE_BITS bits
// (at most 32) of in_value are converted.
// Output: the decimal digits leave most significant first, one per cycle,
// each shown for one cycle with out_valid high; out_last marks the final
// digit. Leading zeros are dropped; zero gives a single '0'.
// Structure (VALUE_BITS = 32): a double-dabble datapath takes 4 input bits per
// cycle, then a digit shifter walks all 10 BCD positions, one per cycle,
// skipping leading zeros. Busy stays high through the conversion and the
// walk; the first digit appears during the walk and the last at its final
// position. A new transaction can be accepted the cycle busy is low again.
// The receiver cannot stall: out_valid is a strobe and must be taken.
// Reset (rst_n low, synchronous) returns the controller to idle and drops
// any transaction in progress.
module binary_to_decimal_ascii_core import b2da_pkg::*; #(
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic [IN_W-1:0]   in_value,
  output logic              out_valid,
  output logic [CHAR_W-1:0] out_digit_char,
  output logic              out_last
);

  cmd_t  cmd;
  stat_t stat;

  b2da_ctrl #(.VALUE_BITS(VALUE_BITS)) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .stat      (stat),
    .cmd       (cmd),
    .busy      (busy),
    .out_valid (out_valid),
    .out_last  (out_last)
  );

  b2da_dp #(.VALUE_BITS(VALUE_BITS)) u_dp (
    .clk        (clk),
    .in_value   (in_value),
    .cmd        (cmd),
    .stat       (stat),
    .digit_char (out_digit_char)
  );

endmodule

@@ hdl/b2da_chk.sv @@
`timescale 1ns / 1ps

module b2da_chk import b2da_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              start,
  input logic              busy,
  input logic              out_valid,
  input logic [CHAR_W-1:0] out_digit_char,
  input logic              out_last
);

  a_valid_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy)
    else $error("digit strobe outside a transaction");

  a_last_strobed: assert property (@(posedge clk) disable iff (!rst_n)
    out_last |-> out_valid)
    else $error("last flag without strobe");

  a_digit_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_digit_char >= ASCII_ZERO) &&
                  (out_digit_char <= ASCII_ZERO + CHAR_W'(9)))
    else $error("digit character out of range");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("busy did not rise after acceptance");

  a_end_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    ($fell(busy) && $past(rst_n)) |-> $past(out_last))
    else $error("transaction ended without a last digit");

endmodule

bind binary_to_decimal_ascii_core b2da_chk u_b2da_chk (.*);
